>>> rtl/core/wcl_pkg.sv
`timescale 1ns / 1ps

package wcl_pkg;

  // configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CHAR_W  = 8;

  // mode codes; the unused code behaves as collapse only
  localparam logic [1:0] MODE_COLLAPSE  = 2'd0;
  localparam logic [1:0] MODE_WORDS     = 2'd1;
  localparam logic [1:0] MODE_SENTENCES = 2'd2;

  localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> rtl/core/whitespace_collapse_line_wrap_unit.sv
`timescale 1ns / 1ps

// channel | handshake           | payload
// --------+---------------------+---------------------------
// in      | in_valid, in_stall  | in_char
// out     | out_valid, out_stall| out_char, last_of_run
// cfg     | cfg_we              | cfg_index, cfg_data
//
// a text byte is decided in the cycle of its transfer and its results land in
// a two-byte result register; the output side drains that register one byte
// per cycle while out_stall is low; an item giving one byte then sustains one
// item per cycle. an item of two bytes (line break or inserted space first)
// holds input until its first byte leaves. whitespace bytes give no result.
// rst is synchronous and active high: state returns to line start, mode 0 and
// count 1. in_stall rises while the result register cannot take a new item,
// so a stall on the output holds input back within the same cycle.

module whitespace_collapse_line_wrap_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [wcl_pkg::COUNT_W-1:0]   cfg_data,
  // input text bytes
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wcl_pkg::CHAR_W-1:0]    in_char,
  // output bytes
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wcl_pkg::CHAR_W-1:0]    out_char,
  output logic                          last_of_run
);

  // configuration registers
  logic [1:0]                    mode;
  logic [wcl_pkg::COUNT_W-1:0]   count_per_line;

  // text state
  logic                          pending_space;
  logic                          at_line_start;
  logic [wcl_pkg::COUNT_W-1:0]   word_count;
  logic [wcl_pkg::COUNT_W-1:0]   sentence_count;
  logic                          after_dot;

  // result register: up to two bytes, byte0 is shown first
  logic [1:0]                    res_count;
  logic [wcl_pkg::CHAR_W-1:0]    res_byte0;
  logic [wcl_pkg::CHAR_W-1:0]    res_byte1;

  logic                          in_xfer;
  logic                          out_xfer;

  // next-state values from the current byte
  logic                          pending_space_next;
  logic                          at_line_start_next;
  logic [wcl_pkg::COUNT_W-1:0]   word_count_next;
  logic [wcl_pkg::COUNT_W-1:0]   sentence_count_next;
  logic                          after_dot_next;
  logic                          is_ws;
  logic                          prefix_valid;
  logic [wcl_pkg::CHAR_W-1:0]    prefix_char;

  assign out_valid   = (res_count != 2'd0);
  assign out_char    = res_byte0;
  assign last_of_run = (res_count == 2'd1);
  assign out_xfer    = out_valid && !out_stall;

  // room when empty, or when the last byte leaves this cycle
  assign in_stall = !((res_count == 2'd0) || ((res_count == 2'd1) && !out_stall));
  assign in_xfer  = in_valid && !in_stall;

  // decide what one byte emits and how the state moves
  always_comb begin
    logic                        gap;
    logic                        sol;
    logic                        is_dot;
    logic [wcl_pkg::COUNT_W-1:0] cnt_inc;

    is_ws   = wcl_pkg::is_space(in_char);
    is_dot  = (in_char == wcl_pkg::CH_DOT);
    gap     = pending_space;
    sol     = at_line_start;
    cnt_inc = '0;

    pending_space_next  = pending_space;
    at_line_start_next  = at_line_start;
    word_count_next     = word_count;
    sentence_count_next = sentence_count;
    after_dot_next      = after_dot;
    prefix_valid        = 1'b0;
    prefix_char         = wcl_pkg::CH_SP;

    if (is_ws) begin
      pending_space_next = 1'b1;
    end else begin
      case (mode)
        wcl_pkg::MODE_WORDS: begin
          // a gap after a word on this line closes that word
          if (!sol && gap) begin
            cnt_inc = word_count + 1'b1;
            if (cnt_inc == count_per_line) begin
              word_count_next = '0;
              prefix_valid    = 1'b1;
              prefix_char     = wcl_pkg::CH_NL;
              sol             = 1'b1;
            end else begin
              word_count_next = cnt_inc;
            end
          end
        end
        wcl_pkg::MODE_SENTENCES: begin
          // at line start a pending gap counts for nothing
          if (sol) begin
            gap = 1'b0;
          end
          sol = 1'b0;
          if (is_dot && !after_dot) begin
            after_dot_next = 1'b1;
          end else if (after_dot && (!is_dot || gap)) begin
            // dot run closed: one more sentence
            cnt_inc        = sentence_count + 1'b1;
            after_dot_next = is_dot;
            if (cnt_inc == count_per_line) begin
              sentence_count_next = '0;
              prefix_valid        = 1'b1;
              prefix_char         = wcl_pkg::CH_NL;
              sol                 = 1'b1;
            end else begin
              sentence_count_next = cnt_inc;
              if (!gap) begin
                // space after a dot that had none
                prefix_valid = 1'b1;
                prefix_char  = wcl_pkg::CH_SP;
                sol          = 1'b1;
              end
            end
          end
        end
        default: begin
          // collapse only
        end
      endcase

      if (gap && !sol) begin
        prefix_valid = 1'b1;
        prefix_char  = wcl_pkg::CH_SP;
      end

      pending_space_next = 1'b0;
      at_line_start_next = 1'b0;
    end
  end

  // configuration and text state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= wcl_pkg::MODE_COLLAPSE;
      count_per_line <= wcl_pkg::COUNT_W'(1);
      pending_space  <= 1'b0;
      at_line_start  <= 1'b1;
      word_count     <= '0;
      sentence_count <= '0;
      after_dot      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wcl_pkg::REG_MODE:  mode           <= cfg_data[1:0];
          wcl_pkg::REG_COUNT: count_per_line <= cfg_data;
          default:            mode           <= mode;
        endcase
      end
      if (in_xfer) begin
        pending_space  <= pending_space_next;
        at_line_start  <= at_line_start_next;
        word_count     <= word_count_next;
        sentence_count <= sentence_count_next;
        after_dot      <= after_dot_next;
      end
    end
  end

  // result register fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 2'd0;
    end else if (in_xfer && !is_ws) begin
      res_count <= prefix_valid ? 2'd2 : 2'd1;
    end else if (out_xfer) begin
      res_count <= res_count - 2'd1;
    end
  end

  // result bytes, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer && !is_ws) begin
      res_byte0 <= prefix_valid ? prefix_char : in_char;
      res_byte1 <= in_char;
    end else if (out_xfer) begin
      res_byte0 <= res_byte1;
    end
  end

endmodule
